// ===== hw/rtl/lpip_pkg.sv =====
// ----------------------------------------------------------------------------
// lpip_pkg
// Shared types, widths, register codes and the reflectance color table of the
// lidar point image projector.
// ----------------------------------------------------------------------------
package lpip_pkg;

  localparam int COORD_FRAC_BITS = 8;

  localparam int COORD_W = 16;
  localparam int COEF_W  = 32;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int NUM_W   = ACC_W + 2;
  localparam int POS_W   = 12;
  localparam int LIM_W   = 13;
  localparam int RAD_W   = 32;
  localparam int ROOT_W  = 16;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam int MAC_STAGES   = 3;
  localparam int DIV_STAGES   = POS_W + 1;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int ALIGN_STAGES = SQRT_STAGES - DIV_STAGES;
  localparam int PIPE_LEN     = 1 + MAC_STAGES + SQRT_STAGES;

  localparam logic [15:0]      DEPTH_GAIN_SQ = 16'd41616;
  localparam logic [LIM_W-1:0] MAX_DIM       = 13'd4096;
  localparam logic [LIM_W-1:0] WIDTH_RESET   = 13'd1242;
  localparam logic [LIM_W-1:0] HEIGHT_RESET  = 13'd375;

  localparam logic [2:0] REG_ROW0_AB = 3'd0;
  localparam logic [2:0] REG_ROW0_CD = 3'd1;
  localparam logic [2:0] REG_ROW1_AB = 3'd2;
  localparam logic [2:0] REG_ROW1_CD = 3'd3;
  localparam logic [2:0] REG_ROW2_AB = 3'd4;
  localparam logic [2:0] REG_ROW2_CD = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  typedef struct packed {
    logic [2:0][3:0][COEF_W-1:0] coef;
    logic [LIM_W-1:0]            lim_col;
    logic [LIM_W-1:0]            lim_row;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic             neg;
    logic             kill;
  } place_in_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             ok;
  } place_out_t;

  typedef struct packed {
    place_out_t col;
    place_out_t row;
  } place_pair_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] den;
    logic [POS_W-1:0] q;
    logic             neg;
    logic             kill;
  } div_stage_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

  typedef struct packed {
    logic       v;
    logic       xpos;
    logic [7:0] refl;
  } meta_t;

  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ROOT_W-1:0] depth;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        gray;
  } result_t;

  function automatic logic [31:0] color_entry(int code);
    int wl;
    int r;
    int g;
    int b;
    int y;
    wl = 119850 + 310 * code;
    if (wl < 124950) begin
      r = 0; g = (wl - 112200) / 50; b = 255; y = g;
    end else if (wl < 130050) begin
      r = 0; g = 255; b = (130050 - wl) / 20; y = b;
    end else if (wl < 147900) begin
      r = (wl - 130050) / 70; g = 255; b = 0; y = r;
    end else if (wl < 164475) begin
      r = 255; g = (164475 - wl) / 65; b = 0; y = g;
    end else begin
      r = 255; g = 0; b = 0; y = 255;
    end
    return {r[7:0], g[7:0], b[7:0], y[7:0]};
  endfunction

  function automatic logic [255:0][31:0] build_color_lut();
    logic [255:0][31:0] lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = color_entry(i);
    end
    return lut;
  endfunction

  localparam logic [255:0][31:0] COLOR_LUT = build_color_lut();

endpackage

// ===== hw/rtl/lpip_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lpip_cfg_regs
// APB register file: projection matrix rows and image size limits.
// ----------------------------------------------------------------------------
module lpip_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpip_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lpip_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lpip_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output lpip_pkg::cfg_t                      cfg_o
);

  logic [5:0][lpip_pkg::CFG_DATA_W-1:0] row_q;
  logic [lpip_pkg::LIM_W-1:0]           width_q;
  logic [lpip_pkg::LIM_W-1:0]           height_q;
  logic [2:0]                           idx;
  logic                                 wr;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      width_q  <= lpip_pkg::WIDTH_RESET;
      height_q <= lpip_pkg::HEIGHT_RESET;
    end else if (wr) begin
      unique case (idx) inside
        lpip_pkg::REG_ROW0_AB, lpip_pkg::REG_ROW0_CD, lpip_pkg::REG_ROW1_AB,
        lpip_pkg::REG_ROW1_CD, lpip_pkg::REG_ROW2_AB, lpip_pkg::REG_ROW2_CD: begin
          row_q[idx] <= pwdata;
        end
        lpip_pkg::REG_WIDTH:  width_q  <= pwdata[lpip_pkg::LIM_W-1:0];
        lpip_pkg::REG_HEIGHT: height_q <= pwdata[lpip_pkg::LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      lpip_pkg::REG_ROW0_AB, lpip_pkg::REG_ROW0_CD, lpip_pkg::REG_ROW1_AB,
      lpip_pkg::REG_ROW1_CD, lpip_pkg::REG_ROW2_AB, lpip_pkg::REG_ROW2_CD: begin
        prdata = row_q[idx];
      end
      lpip_pkg::REG_WIDTH:  prdata = lpip_pkg::CFG_DATA_W'(width_q);
      lpip_pkg::REG_HEIGHT: prdata = lpip_pkg::CFG_DATA_W'(height_q);
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c % 2 == 0) begin
          cfg_o.coef[r][c] = row_q[2 * r + c / 2][63:32];
        end else begin
          cfg_o.coef[r][c] = row_q[2 * r + c / 2][31:0];
        end
      end
    end
    cfg_o.lim_col = (width_q > lpip_pkg::MAX_DIM) ? lpip_pkg::MAX_DIM : width_q;
    cfg_o.lim_row = (height_q > lpip_pkg::MAX_DIM) ? lpip_pkg::MAX_DIM : height_q;
  end

endmodule

// ===== hw/rtl/lpip_proj_mac.sv =====
// ----------------------------------------------------------------------------
// lpip_proj_mac
// Three-stage matrix multiply-accumulate: products, sums, and preparation of
// the rounding divisions and the scaled range radicand.
// ----------------------------------------------------------------------------
module lpip_proj_mac (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  lpip_pkg::point_t              pt_i,
  input  lpip_pkg::cfg_t                cfg_i,
  output lpip_pkg::place_in_t           place_u_o,
  output lpip_pkg::place_in_t           place_v_o,
  output logic [lpip_pkg::RAD_W-1:0]    rad_o
);

  logic signed [lpip_pkg::COORD_W-1:0] p [4];
  logic signed [lpip_pkg::PROD_W-1:0]  prod_q [3][4];
  logic [31:0]                         sq_q [3];
  logic signed [lpip_pkg::ACC_W-1:0]   acc_q [3];
  logic [31:0]                         s_q;
  logic [lpip_pkg::ACC_W-1:0]          mag_u;
  logic [lpip_pkg::ACC_W-1:0]          mag_v;
  logic [lpip_pkg::NUM_W-1:0]          w_ext;
  logic                                wpos;
  logic [47:0]                         gain_prod;
  lpip_pkg::place_in_t                 place_u_q;
  lpip_pkg::place_in_t                 place_v_q;
  logic [lpip_pkg::RAD_W-1:0]          rad_q;

  always_comb begin
    p[0] = pt_i.x;
    p[1] = pt_i.y;
    p[2] = pt_i.z;
    p[3] = lpip_pkg::COORD_W'(1 << lpip_pkg::COORD_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= $signed(cfg_i.coef[r][c]) * p[c];
        end
      end
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= 32'(p[k]) * 32'(p[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= lpip_pkg::ACC_W'(prod_q[r][0]) + lpip_pkg::ACC_W'(prod_q[r][1])
                  + lpip_pkg::ACC_W'(prod_q[r][2]) + lpip_pkg::ACC_W'(prod_q[r][3]);
      end
      s_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  always_comb begin
    mag_u     = acc_q[0][lpip_pkg::ACC_W-1] ? lpip_pkg::ACC_W'(-acc_q[0])
                                            : lpip_pkg::ACC_W'(acc_q[0]);
    mag_v     = acc_q[1][lpip_pkg::ACC_W-1] ? lpip_pkg::ACC_W'(-acc_q[1])
                                            : lpip_pkg::ACC_W'(acc_q[1]);
    w_ext     = lpip_pkg::NUM_W'($unsigned(acc_q[2]));
    wpos      = !acc_q[2][lpip_pkg::ACC_W-1] && (acc_q[2] != '0);
    gain_prod = s_q * lpip_pkg::DEPTH_GAIN_SQ;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      place_u_q.num  <= lpip_pkg::NUM_W'({mag_u, 1'b0}) + w_ext;
      place_u_q.den  <= lpip_pkg::NUM_W'({acc_q[2], 1'b0});
      place_u_q.neg  <= acc_q[0][lpip_pkg::ACC_W-1];
      place_u_q.kill <= !wpos;
      place_v_q.num  <= lpip_pkg::NUM_W'({mag_v, 1'b0}) + w_ext;
      place_v_q.den  <= lpip_pkg::NUM_W'({acc_q[2], 1'b0});
      place_v_q.neg  <= acc_q[1][lpip_pkg::ACC_W-1];
      place_v_q.kill <= !wpos;
      rad_q          <= gain_prod[47:16];
    end
  end

  assign place_u_o = place_u_q;
  assign place_v_o = place_v_q;
  assign rad_o     = rad_q;

endmodule

// ===== hw/rtl/lpip_place_div.sv =====
// ----------------------------------------------------------------------------
// lpip_place_div
// Pipelined restoring divider for round(num/w): range precheck stage, then one
// quotient bit per stage, then bounds check against the image limit.
// ----------------------------------------------------------------------------
module lpip_place_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  lpip_pkg::place_in_t         place_i,
  input  logic [lpip_pkg::LIM_W-1:0]  lim_i,
  output lpip_pkg::place_out_t        place_o
);

  localparam int WIDE_W = lpip_pkg::NUM_W + lpip_pkg::POS_W;

  lpip_pkg::div_stage_t stage_q [lpip_pkg::DIV_STAGES];
  logic                 ovf;

  assign ovf = WIDE_W'(place_i.num) >= (WIDE_W'(place_i.den) << lpip_pkg::POS_W);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0].rem  <= place_i.num;
      stage_q[0].den  <= place_i.den;
      stage_q[0].q    <= '0;
      stage_q[0].neg  <= place_i.neg;
      stage_q[0].kill <= place_i.kill | ovf;
    end
  end

  for (genvar k = 1; k < lpip_pkg::DIV_STAGES; k++) begin : g_step
    localparam int B = lpip_pkg::POS_W - k;
    logic [WIDE_W-1:0]    sh;
    lpip_pkg::div_stage_t nxt_d;

    always_comb begin
      sh    = WIDE_W'(stage_q[k-1].den) << B;
      nxt_d = stage_q[k-1];
      if (WIDE_W'(stage_q[k-1].rem) >= sh) begin
        nxt_d.rem  = stage_q[k-1].rem - sh[lpip_pkg::NUM_W-1:0];
        nxt_d.q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt_d;
      end
    end
  end

  always_comb begin
    place_o.pos = stage_q[lpip_pkg::DIV_STAGES-1].q;
    place_o.ok  = !stage_q[lpip_pkg::DIV_STAGES-1].kill
               && !(stage_q[lpip_pkg::DIV_STAGES-1].neg
                    && (stage_q[lpip_pkg::DIV_STAGES-1].q != '0))
               && ({1'b0, stage_q[lpip_pkg::DIV_STAGES-1].q} < lim_i);
  end

endmodule

// ===== hw/rtl/lpip_isqrt.sv =====
// ----------------------------------------------------------------------------
// lpip_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lpip_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lpip_pkg::RAD_W-1:0]   rad_i,
  output logic [lpip_pkg::ROOT_W-1:0]  root_o
);

  localparam int T_W = lpip_pkg::RAD_W + 2;

  lpip_pkg::sqrt_stage_t stage_q [lpip_pkg::SQRT_STAGES];

  for (genvar k = 0; k < lpip_pkg::SQRT_STAGES; k++) begin : g_step
    localparam int I = lpip_pkg::ROOT_W - 1 - k;
    lpip_pkg::sqrt_stage_t prv;
    lpip_pkg::sqrt_stage_t nxt_d;
    logic [T_W-1:0]        trial;

    if (k == 0) begin : g_src_in
      assign prv.rem  = rad_i;
      assign prv.root = '0;
    end else begin : g_src_stage
      assign prv = stage_q[k-1];
    end

    always_comb begin
      trial = (T_W'(prv.root) << (I + 1)) + (T_W'(1) << (2 * I));
      nxt_d = prv;
      if (T_W'(prv.rem) >= trial) begin
        nxt_d.rem     = prv.rem - trial[lpip_pkg::RAD_W-1:0];
        nxt_d.root[I] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt_d;
      end
    end
  end

  assign root_o = stage_q[lpip_pkg::SQRT_STAGES-1].root;

endmodule

// ===== hw/rtl/lidar_point_image_projector_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_image_projector_core
// Throughput: one point per cycle while in_stall_o is low, set by the fully
// pipelined multiply, divide and square-root stages; an output skid register
// absorbs one stall.
// Reset: clears all valid bits, zeroes the matrix, sets 1242 x 375 limits.
// Dropped points leave the pipeline as empty slots and give no transfer.
// ----------------------------------------------------------------------------
module lidar_point_image_projector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lpip_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lpip_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lpip_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [15:0]               point_x_i,
  input  logic signed [15:0]               point_y_i,
  input  logic signed [15:0]               point_z_i,
  input  logic [7:0]                       reflect_code_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [11:0]                      pixel_row_o,
  output logic [11:0]                      pixel_col_o,
  output logic [15:0]                      depth_scaled_o,
  output logic [7:0]                       color_red_o,
  output logic [7:0]                       color_green_o,
  output logic [7:0]                       color_blue_o,
  output logic [7:0]                       gray_level_o
);

  lpip_pkg::cfg_t         cfg;
  lpip_pkg::point_t       pt_q;
  lpip_pkg::meta_t        meta_q [lpip_pkg::PIPE_LEN];
  lpip_pkg::place_in_t    place_u;
  lpip_pkg::place_in_t    place_v;
  logic [lpip_pkg::RAD_W-1:0]  rad;
  lpip_pkg::place_out_t   col_res;
  lpip_pkg::place_out_t   row_res;
  lpip_pkg::place_pair_t  al_q [lpip_pkg::ALIGN_STAGES];
  logic [lpip_pkg::ROOT_W-1:0] root;
  lpip_pkg::meta_t        last;
  lpip_pkg::place_pair_t  al_last;
  logic [31:0]            color;
  logic                   keep;
  logic                   en;
  lpip_pkg::result_t      item;
  lpip_pkg::result_t      out_q;
  lpip_pkg::result_t      skid_q;
  logic                   out_v_q;
  logic                   skid_v_q;

  lpip_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lpip_pkg::PIPE_LEN; k++) begin
        meta_q[k] <= '0;
      end
    end else if (en) begin
      meta_q[0].v    <= in_valid_i;
      meta_q[0].xpos <= !point_x_i[15];
      meta_q[0].refl <= reflect_code_i;
      for (int k = 1; k < lpip_pkg::PIPE_LEN; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q.x <= point_x_i;
      pt_q.y <= point_y_i;
      pt_q.z <= point_z_i;
    end
  end

  lpip_proj_mac u_mac (
    .clk_i     (clk_i),
    .en_i      (en),
    .pt_i      (pt_q),
    .cfg_i     (cfg),
    .place_u_o (place_u),
    .place_v_o (place_v),
    .rad_o     (rad)
  );

  lpip_place_div u_div_col (
    .clk_i   (clk_i),
    .en_i    (en),
    .place_i (place_u),
    .lim_i   (cfg.lim_col),
    .place_o (col_res)
  );

  lpip_place_div u_div_row (
    .clk_i   (clk_i),
    .en_i    (en),
    .place_i (place_v),
    .lim_i   (cfg.lim_row),
    .place_o (row_res)
  );

  lpip_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      al_q[0].col <= col_res;
      al_q[0].row <= row_res;
      for (int k = 1; k < lpip_pkg::ALIGN_STAGES; k++) begin
        al_q[k] <= al_q[k-1];
      end
    end
  end

  always_comb begin
    last       = meta_q[lpip_pkg::PIPE_LEN-1];
    al_last    = al_q[lpip_pkg::ALIGN_STAGES-1];
    color      = lpip_pkg::COLOR_LUT[last.refl];
    keep       = last.v && last.xpos && al_last.col.ok && al_last.row.ok;
    item.row   = al_last.row.pos;
    item.col   = al_last.col.pos;
    item.depth = root;
    item.red   = color[31:24];
    item.green = color[23:16];
    item.blue  = color[15:8];
    item.gray  = color[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= keep;
      end
    end else if (keep) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : item;
    end else if (en && keep) begin
      skid_q <= item;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pixel_row_o    = out_q.row;
  assign pixel_col_o    = out_q.col;
  assign depth_scaled_o = out_q.depth;
  assign color_red_o    = out_q.red;
  assign color_green_o  = out_q.green;
  assign color_blue_o   = out_q.blue;
  assign gray_level_o   = out_q.gray;

endmodule
